[hw/rtl/wspd_pkg.sv]
`default_nettype none

package wspd_pkg;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int THR_W    = 10;
   localparam int SLOPE_W  = 10;

   // Window length and the fixed least-squares terms that follow from it
   localparam int     WINDOW  = 20;
   localparam longint LWIN    = longint'(WINDOW);
   localparam longint SMP_MAX = (longint'(1) << SAMPLE_W) - 1;
   localparam longint SX      = LWIN * (LWIN + 1) / 2;
   localparam longint SX2     = LWIN * (LWIN + 1) * (2 * LWIN + 1) / 6;
   localparam longint DEN     = LWIN * SX2 - SX * SX;

   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int WPROD_W = SAMPLE_W + CNT_W;
   localparam int SS_W    = $clog2(LWIN * SMP_MAX + 1);
   localparam int SW_W    = $clog2(SX * SMP_MAX + 1);
   localparam int PROD_W  = $clog2(LWIN * SX * SMP_MAX + 1);
   localparam int NUM_W   = PROD_W + 1;

   // Quotient magnitude is capped at QCAP; beyond that only the sign matters
   localparam int     QM_W   = SLOPE_W;
   localparam int     Q_W    = QM_W + 1;
   localparam longint QCAP   = (longint'(1) << QM_W) - 1;
   localparam longint LIM    = (QCAP + 1) * DEN;
   localparam int     MAG_W  = $clog2(LIM);
   localparam int     CMP_W  = ((PROD_W > MAG_W) ? PROD_W : MAG_W) + 1;
   localparam longint RECIP  = (longint'(1) << MAG_W) / DEN;
   localparam int     RECIP_W = $clog2(RECIP + 1);
   localparam int     QPROD_W = MAG_W + RECIP_W;
   localparam int     DEN_W   = $clog2(DEN + 1);
   localparam int     CHK_W   = QM_W + 1 + DEN_W;

   localparam longint SLOPE_MAX = (longint'(1) << (SLOPE_W - 1)) - 1;
   localparam longint SLOPE_MIN = -(longint'(1) << (SLOPE_W - 1));

   // Input register, five slope stages and the last stage ahead of the result register
   localparam int PIPE_STAGES = 7;

   // Register file
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      CSR_ZONE_LOW,
      CSR_ZONE_HIGH,
      CSR_TREND_MIN
   } csr_index_type;

   localparam logic [SAMPLE_W-1:0]     ZONE_LOW_RST  = SAMPLE_W'(10000);
   localparam logic [SAMPLE_W-1:0]     ZONE_HIGH_RST = SAMPLE_W'(16000);
   localparam logic signed [THR_W-1:0] TREND_MIN_RST = THR_W'(1);

endpackage

`default_nettype wire

[hw/rtl/wspd_req_if.sv]
`default_nettype none

interface wspd_req_if;
   logic                          valid;
   logic                          ready;
   logic [wspd_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

[hw/rtl/wspd_rsp_if.sv]
`default_nettype none

interface wspd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                presence_flag;
   logic signed [wspd_pkg::SLOPE_W-1:0] last_slope;
   logic                                window_done;

   modport source (output valid, output presence_flag, output last_slope,
                   output window_done, input ready);
   modport sink   (input valid, input presence_flag, input last_slope,
                   input window_done, output ready);
endinterface

`default_nettype wire

[hw/rtl/windowed_slope_presence_detector.sv]
`default_nettype none

// Windowed slope presence detector. Each request transfer carries one sensor
// sample; a sample strictly between zone_low and zone_high joins a window of
// WINDOW samples (20), held as a running sum and a position-weighted sum. The
// sample that fills the window triggers the least-squares slope against
// positions 1..WINDOW, truncated toward zero: the presence flag is set when
// the slope reaches slope_threshold and cleared otherwise, and the window
// restarts. A sample outside the zone clears the flag and restarts the
// window. Every request gives exactly one response transfer: the flag after
// that sample, the last computed slope (saturated to -512..511) and
// window_done. The block takes one sample per clock cycle while responses are
// taken; each response leaves the result register after its request passes
// the input register and the slope stages. The running sums are updated as a
// sample leaves the input register; the slope is then worked through a
// six-stage pipeline (sums, constant products, difference, magnitude,
// reciprocal multiply, correction) before the result register. Each stage
// has its own valid bit and moves up whenever the stage ahead is empty or
// moving, so requests keep flowing into empty stages while a response waits
// to be taken. Registers sit on the APB port at 0x0 zone_low, 0x4 zone_high,
// 0x8 slope_threshold; write them only while the block is idle.

module windowed_slope_presence_detector (
   input  wire logic                             clock,
   input  wire logic                             reset,
   wspd_req_if.sink                              req_ch,
   wspd_rsp_if.source                            rsp_ch,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [wspd_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [wspd_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [wspd_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                  pready
);

   typedef enum logic [1:0] {
      KIND_MISS,
      KIND_FILL,
      KIND_DONE
   } kind_type;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [wspd_pkg::SAMPLE_W-1:0]     zone_low_ff;
   logic [wspd_pkg::SAMPLE_W-1:0]     zone_high_ff;
   logic signed [wspd_pkg::THR_W-1:0] trend_min_ff;
   wspd_pkg::csr_index_type           csr_idx;
   logic                              csr_wr;

   assign pready  = 1'b1;
   assign csr_idx = wspd_pkg::csr_index_type'(paddr[3:2]);
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_low_ff  <= wspd_pkg::ZONE_LOW_RST;
         zone_high_ff <= wspd_pkg::ZONE_HIGH_RST;
         trend_min_ff <= wspd_pkg::TREND_MIN_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            wspd_pkg::CSR_ZONE_LOW: begin
               zone_low_ff <= pwdata[wspd_pkg::SAMPLE_W-1:0];
            end
            wspd_pkg::CSR_ZONE_HIGH: begin
               zone_high_ff <= pwdata[wspd_pkg::SAMPLE_W-1:0];
            end
            wspd_pkg::CSR_TREND_MIN: begin
               trend_min_ff <= pwdata[wspd_pkg::THR_W-1:0];
            end
            default: begin
               // unmapped address: drop the write
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         wspd_pkg::CSR_ZONE_LOW:  prdata = wspd_pkg::CSR_DATA_W'(zone_low_ff);
         wspd_pkg::CSR_ZONE_HIGH: prdata = wspd_pkg::CSR_DATA_W'(zone_high_ff);
         wspd_pkg::CSR_TREND_MIN: prdata = wspd_pkg::CSR_DATA_W'(trend_min_ff);
         default:                 prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Stage flow: a stage loads when it is empty or its contents move on.
   // en[PIPE_STAGES] belongs to the result register.
   // ------------------------------------------------------------------
   logic v_ff [0:wspd_pkg::PIPE_STAGES-1];
   logic en   [0:wspd_pkg::PIPE_STAGES];
   logic rsp_valid_ff;

   always_comb begin
      en[wspd_pkg::PIPE_STAGES] = !rsp_valid_ff || rsp_ch.ready;
      for (int k = wspd_pkg::PIPE_STAGES - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_ch.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < wspd_pkg::PIPE_STAGES; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_ch.valid;
         end
         for (int k = 1; k < wspd_pkg::PIPE_STAGES; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // Stage 0: input register
   logic [wspd_pkg::SAMPLE_W-1:0] sample0_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         sample0_ff <= req_ch.sample;
      end
   end

   // ------------------------------------------------------------------
   // Window accumulation, done as the sample leaves stage 0
   // ------------------------------------------------------------------
   logic [wspd_pkg::CNT_W-1:0]   fill_count_ff;
   logic [wspd_pkg::SS_W-1:0]    sum_samples_ff;
   logic [wspd_pkg::SW_W-1:0]    sum_weighted_ff;
   logic                         fire0;
   logic                         in_zone;
   logic                         win_full;
   logic [wspd_pkg::CNT_W-1:0]   cnt_next;
   logic [wspd_pkg::WPROD_W-1:0] wprod;
   logic [wspd_pkg::SS_W-1:0]    ss_next;
   logic [wspd_pkg::SW_W-1:0]    sw_next;
   kind_type                     kind0;

   assign fire0    = v_ff[0] && en[1];
   assign in_zone  = (sample0_ff > zone_low_ff) && (sample0_ff < zone_high_ff);
   assign cnt_next = fill_count_ff + wspd_pkg::CNT_W'(1);
   assign win_full = (cnt_next == wspd_pkg::CNT_W'(wspd_pkg::WINDOW));
   assign wprod    = wspd_pkg::WPROD_W'(sample0_ff) * wspd_pkg::WPROD_W'(cnt_next);
   assign ss_next  = sum_samples_ff + wspd_pkg::SS_W'(sample0_ff);
   assign sw_next  = sum_weighted_ff + wspd_pkg::SW_W'(wprod);
   assign kind0    = !in_zone ? KIND_MISS : (win_full ? KIND_DONE : KIND_FILL);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff   <= '0;
         sum_samples_ff  <= '0;
         sum_weighted_ff <= '0;
      end else if (fire0) begin
         if (in_zone && !win_full) begin
            fill_count_ff   <= cnt_next;
            sum_samples_ff  <= ss_next;
            sum_weighted_ff <= sw_next;
         end else begin
            // out of zone or window evaluated: restart the window
            fill_count_ff   <= '0;
            sum_samples_ff  <= '0;
            sum_weighted_ff <= '0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Slope pipeline
   // ------------------------------------------------------------------
   kind_type kind_ff [1:wspd_pkg::PIPE_STAGES-1];

   logic [wspd_pkg::SS_W-1:0]          ss1_ff;
   logic [wspd_pkg::SW_W-1:0]          sw1_ff;
   logic [wspd_pkg::PROD_W-1:0]        pw2_ff;
   logic [wspd_pkg::PROD_W-1:0]        px2_ff;
   logic signed [wspd_pkg::NUM_W-1:0]  num3_ff;
   logic signed [wspd_pkg::NUM_W-1:0]  num3_in;
   logic                               neg4_ff;
   logic                               big4_ff;
   logic [wspd_pkg::MAG_W-1:0]         mag4_ff;
   logic [wspd_pkg::NUM_W-1:0]         abs3;
   logic [wspd_pkg::CMP_W-1:0]         mag_cmp;
   logic                               neg5_ff;
   logic                               big5_ff;
   logic [wspd_pkg::MAG_W-1:0]         mag5_ff;
   logic [wspd_pkg::QM_W-1:0]          q05_ff;
   logic [wspd_pkg::QPROD_W-1:0]       qprod;
   logic                               neg6_ff;
   logic [wspd_pkg::QM_W-1:0]          qm6_ff;
   logic [wspd_pkg::QM_W:0]            q_up;
   logic [wspd_pkg::CHK_W-1:0]         q_up_den;
   logic                               q_short;
   logic [wspd_pkg::QM_W-1:0]          qm6_in;

   // Stage 3: numerator W*sum_weighted - SX*sum_samples
   assign num3_in = $signed({1'b0, pw2_ff}) - $signed({1'b0, px2_ff});

   // Stage 4: sign and magnitude, with a flag for quotients past the cap
   assign abs3    = num3_ff[wspd_pkg::NUM_W-1] ? wspd_pkg::NUM_W'(-num3_ff)
                                               : wspd_pkg::NUM_W'(num3_ff);
   assign mag_cmp = wspd_pkg::CMP_W'(abs3[wspd_pkg::PROD_W-1:0]);

   // Stage 5: estimate of mag / DEN, low by at most one
   assign qprod = wspd_pkg::QPROD_W'(mag4_ff) * wspd_pkg::QPROD_W'(wspd_pkg::RECIP);

   // Stage 6: bump the estimate when another whole divisor still fits
   assign q_up     = {1'b0, q05_ff} + (wspd_pkg::QM_W + 1)'(1);
   assign q_up_den = wspd_pkg::CHK_W'(q_up) * wspd_pkg::CHK_W'(wspd_pkg::DEN);
   assign q_short  = wspd_pkg::CHK_W'(mag5_ff) >= q_up_den;
   assign qm6_in   = big5_ff ? wspd_pkg::QM_W'(wspd_pkg::QCAP)
                   : (q_short ? q_up[wspd_pkg::QM_W-1:0] : q05_ff);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         kind_ff[1] <= kind0;
         ss1_ff     <= ss_next;
         sw1_ff     <= sw_next;
      end
      if (en[2]) begin
         kind_ff[2] <= kind_ff[1];
         pw2_ff     <= wspd_pkg::PROD_W'(sw1_ff) * wspd_pkg::PROD_W'(wspd_pkg::WINDOW);
         px2_ff     <= wspd_pkg::PROD_W'(ss1_ff) * wspd_pkg::PROD_W'(wspd_pkg::SX);
      end
      if (en[3]) begin
         kind_ff[3] <= kind_ff[2];
         num3_ff    <= num3_in;
      end
      if (en[4]) begin
         kind_ff[4] <= kind_ff[3];
         neg4_ff    <= num3_ff[wspd_pkg::NUM_W-1];
         big4_ff    <= mag_cmp >= wspd_pkg::CMP_W'(wspd_pkg::LIM);
         mag4_ff    <= wspd_pkg::MAG_W'(mag_cmp);
      end
      if (en[5]) begin
         kind_ff[5] <= kind_ff[4];
         neg5_ff    <= neg4_ff;
         big5_ff    <= big4_ff;
         mag5_ff    <= mag4_ff;
         q05_ff     <= qprod[wspd_pkg::MAG_W +: wspd_pkg::QM_W];
      end
      if (en[6]) begin
         kind_ff[6] <= kind_ff[5];
         neg6_ff    <= neg5_ff;
         qm6_ff     <= qm6_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register; flag and slope are also the detector state
   // ------------------------------------------------------------------
   logic signed [wspd_pkg::Q_W-1:0]     q_signed;
   logic                                thr_hit;
   logic signed [wspd_pkg::SLOPE_W-1:0] slope_sat;
   logic                                flag_ff;
   logic signed [wspd_pkg::SLOPE_W-1:0] slope_ff;
   logic                                done_ff;
   logic                                load_out;

   assign q_signed = neg6_ff ? -$signed({1'b0, qm6_ff}) : $signed({1'b0, qm6_ff});
   assign thr_hit  = q_signed >= wspd_pkg::Q_W'(trend_min_ff);

   always_comb begin
      if (q_signed > wspd_pkg::Q_W'(wspd_pkg::SLOPE_MAX)) begin
         slope_sat = wspd_pkg::SLOPE_W'(wspd_pkg::SLOPE_MAX);
      end else if (q_signed < wspd_pkg::Q_W'(wspd_pkg::SLOPE_MIN)) begin
         slope_sat = wspd_pkg::SLOPE_W'(wspd_pkg::SLOPE_MIN);
      end else begin
         slope_sat = q_signed[wspd_pkg::SLOPE_W-1:0];
      end
   end

   assign load_out = en[wspd_pkg::PIPE_STAGES] && v_ff[wspd_pkg::PIPE_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         flag_ff      <= 1'b0;
         slope_ff     <= '0;
      end else begin
         if (en[wspd_pkg::PIPE_STAGES]) begin
            rsp_valid_ff <= v_ff[wspd_pkg::PIPE_STAGES-1];
         end
         if (load_out) begin
            case (kind_ff[wspd_pkg::PIPE_STAGES-1])
               KIND_MISS: begin
                  flag_ff <= 1'b0;
               end
               KIND_DONE: begin
                  flag_ff  <= thr_hit;
                  slope_ff <= slope_sat;
               end
               default: begin
                  // window still filling: hold flag and slope
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         done_ff <= (kind_ff[wspd_pkg::PIPE_STAGES-1] == KIND_DONE);
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.presence_flag = flag_ff;
   assign rsp_ch.last_slope    = slope_ff;
   assign rsp_ch.window_done   = done_ff;

endmodule

`default_nettype wire

[hw/rtl/wspd_checker.sv]
`default_nettype none

module wspd_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic                                rsp_presence_flag,
   input wire logic signed [wspd_pkg::SLOPE_W-1:0] rsp_last_slope,
   input wire logic                                rsp_window_done
);

   // no response straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response stays offered
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // a stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && !rsp_ready |=> $stable(rsp_presence_flag)
                       && $stable(rsp_last_slope) && $stable(rsp_window_done))
      else $error("response payload changed while stalled");

   // with no response waiting, every stage can move, so requests are taken
   assert property (@(posedge clock) disable iff (reset)
                    !rsp_valid |-> req_ready)
      else $error("request refused with empty result register");

endmodule

bind windowed_slope_presence_detector wspd_checker u_wspd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_presence_flag (rsp_ch.presence_flag),
   .rsp_last_slope    (rsp_ch.last_slope),
   .rsp_window_done   (rsp_ch.window_done)
);

`default_nettype wire
